// File: rtl/lru_key_value_cache_assert.svh
// Assertion macros shared by the cache modules
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define LKVC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkvc assertion failed: same cycle");
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkvc assertion failed: next cycle");
`else
`define LKVC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CFG_W = 5;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [CFG_W-1:0]        t_cfg;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    localparam t_cfg CFG_RESET  = t_cfg'(16);
    localparam t_val MISS_VALUE = '1;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic lookup;
        logic commit;
        logic hold_addr;
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/lkvc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lkvc_req_if
    import lkvc_pkg::*;
;
    logic valid;
    logic ready;
    logic kind;
    t_key key;
    t_val write_value;

    modport source (output valid, output kind, output key, output write_value, input ready);
    modport sink   (input valid, input kind, input key, input write_value, output ready);
endinterface

`default_nettype wire

// File: rtl/lkvc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lkvc_rsp_if
    import lkvc_pkg::*;
;
    logic valid;
    logic ready;
    logic hit;
    t_val read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

`default_nettype wire

// File: rtl/lkvc_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lkvc_cfg_if
    import lkvc_pkg::*;
;
    logic valid;
    logic ready;
    t_cfg entries_in_use;

    modport source (output valid, output entries_in_use, input ready);
    modport sink   (input valid, input entries_in_use, output ready);
endinterface

`default_nettype wire

// File: rtl/lkvc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/lkvc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "lru_key_value_cache_assert.svh"

module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.lookup    = 1'b0;
        o_cmd.commit    = 1'b0;
        o_cmd.hold_addr = 1'b0;
        n_out_valid     = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.lookup = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.hold_addr = 1'b1;
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    `LKVC_ASSERT_NEXT(a_commit_fills_out, i_clk, i_rst_n, o_cmd.commit, o_out_valid)
    `LKVC_ASSERT_NEXT(a_lookup_then_commit_phase, i_clk, i_rst_n, o_cmd.lookup, o_cmd.hold_addr)
    `LKVC_ASSERT_IMPLY(a_no_accept_in_commit, i_clk, i_rst_n, o_cmd.commit, !o_in_ready)

endmodule

`default_nettype wire

// File: rtl/lkvc_dp.sv
`timescale 1ns / 1ps
`default_nettype none

`include "lru_key_value_cache_assert.svh"

module lkvc_dp
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire logic i_kind,
    input  wire t_key i_key,
    input  wire t_val i_write_value,
    input  wire logic i_cfg_we,
    input  wire t_cfg i_cfg_data,
    output logic      o_hit,
    output t_val      o_read_value
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

    t_key                   r_keys [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]       r_rank [MAX_ENTRIES];
    logic [OCC_W-1:0]       r_occ;
    t_cfg                   r_cfg;

    logic             r_kind;
    t_key             r_key;
    t_val             r_wval;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [IDX_W-1:0] r_hit_rank;
    logic             r_evict;
    logic [IDX_W-1:0] r_vic_idx;
    logic [IDX_W-1:0] r_slot_idx;

    logic [MAX_ENTRIES-1:0] match;
    logic [MAX_ENTRIES-1:0] vic_vec;
    logic [MAX_ENTRIES-1:0] free_vec;
    logic                   hit;
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W-1:0]       hit_rank;
    logic [IDX_W-1:0]       vic_idx;
    logic [IDX_W-1:0]       slot_idx;
    logic [IDX_W-1:0]       occ_m1;
    logic [CMP_W-1:0]       cfg_x;
    logic [CMP_W-1:0]       occ_x;
    logic [CMP_W-1:0]       max_x;
    logic [CMP_W-1:0]       cap_x;
    logic                   evict;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    t_val             ram_rdata;

    assign occ_m1 = IDX_W'(r_occ - OCC_W'(1));
    assign cfg_x  = CMP_W'(r_cfg);
    assign occ_x  = CMP_W'(r_occ);
    assign max_x  = CMP_W'(MAX_ENTRIES);

    always_comb begin
        if (cfg_x == '0) begin
            cap_x = CMP_W'(1);
        end else if (cfg_x > max_x) begin
            cap_x = max_x;
        end else begin
            cap_x = cfg_x;
        end
    end

    assign evict = (occ_x >= cap_x) || (occ_x >= max_x);

    always_comb begin
        match    = '0;
        vic_vec  = '0;
        hit_rank = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match[i]   = r_valid[i] && (r_keys[i] == i_key);
            vic_vec[i] = r_valid[i] && (r_rank[i] == occ_m1);
            if (match[i]) begin
                hit_rank = hit_rank | r_rank[i];
            end
        end
    end

    assign hit      = |match;
    assign free_vec = ~r_valid | (evict ? vic_vec : '0);

    always_comb begin
        hit_idx  = '0;
        vic_idx  = '0;
        slot_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (vic_vec[i]) begin
                vic_idx = IDX_W'(i);
            end
            if (free_vec[i]) begin
                slot_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_kind     <= i_kind;
            r_key      <= i_key;
            r_wval     <= i_write_value;
            r_hit      <= hit;
            r_hit_idx  <= hit_idx;
            r_hit_rank <= hit_rank;
            r_evict    <= evict;
            r_vic_idx  <= vic_idx;
            r_slot_idx <= slot_idx;
        end
        if (i_cmd.commit) begin
            o_hit        <= r_hit;
            o_read_value <= (r_kind == KIND_GET && r_hit) ? ram_rdata : MISS_VALUE;
            if (r_kind == KIND_PUT && !r_hit) begin
                r_keys[r_slot_idx] <= r_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            r_cfg   <= CFG_RESET;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                if (r_hit) begin
                    // promote the hit entry, age the more recent ones
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (IDX_W'(i) == r_hit_idx) begin
                            r_rank[i] <= '0;
                        end else if (r_valid[i] && r_rank[i] < r_hit_rank) begin
                            r_rank[i] <= r_rank[i] + IDX_W'(1);
                        end
                    end
                end else if (r_kind == KIND_PUT) begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (IDX_W'(i) == r_slot_idx) begin
                            r_valid[i] <= 1'b1;
                            r_rank[i]  <= '0;
                        end else if (r_evict && IDX_W'(i) == r_vic_idx) begin
                            r_valid[i] <= 1'b0;
                            r_rank[i]  <= '0;
                        end else if (r_valid[i]) begin
                            r_rank[i] <= r_rank[i] + IDX_W'(1);
                        end
                    end
                    if (!r_evict) begin
                        r_occ <= r_occ + OCC_W'(1);
                    end
                end
            end
        end
    end

    assign ram_we    = i_cmd.commit && (r_kind == KIND_PUT);
    assign ram_waddr = r_hit ? r_hit_idx : r_slot_idx;
    assign ram_raddr = i_cmd.hold_addr ? r_hit_idx : hit_idx;

    lkvc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ENTRIES)
    ) u_values (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_wval),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    `LKVC_ASSERT_IMPLY(a_occ_bound, i_clk, i_rst_n, 1'b1, occ_x <= max_x)
    `LKVC_ASSERT_IMPLY(a_occ_counts_valid, i_clk, i_rst_n, 1'b1, $countones(r_valid) == r_occ)
    `LKVC_ASSERT_IMPLY(a_single_match, i_clk, i_rst_n, i_cmd.lookup, $onehot0(match))

endmodule

`default_nettype wire

// File: rtl/lru_key_value_cache.sv
// Result: the update state that follows item acceptance writes it to the output register.
// Flow: tag compare in the accept cycle, rank and value-memory update in the update state,
//   which waits while the output register still holds an untaken result; one item in flight at a time.
// Reset: synchronous active-low; clears all valid bits, ranks and occupancy,
//   capacity returns to 16; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lkvc_req_if.sink   i_req,
    lkvc_rsp_if.source o_rsp,
    lkvc_cfg_if.sink   i_cfg
);

    t_cmd cmd;

    assign i_cfg.ready = 1'b1;

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    lkvc_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_kind        (i_req.kind),
        .i_key         (i_req.key),
        .i_write_value (i_req.write_value),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_data    (i_cfg.entries_in_use),
        .o_hit         (o_rsp.hit),
        .o_read_value  (o_rsp.read_value)
    );

endmodule

`default_nettype wire

// File: sim/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps

module lru_key_value_cache_tb;
    import lkvc_pkg::*;

    localparam int SLOTS       = 16;
    localparam int RANK_W      = $clog2(SLOTS);
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 112;
    localparam int TABLE_ROWS  = 25;

    localparam logic ROW_ITEM  = 1'b0;
    localparam logic ROW_CFG   = 1'b1;
    localparam logic EXP_OPEN  = 1'b0;
    localparam logic EXP_TYPED = 1'b1;

    typedef struct packed {
        logic row_kind;
        logic kind;
        t_key key;
        t_val write_value;
        t_cfg capacity;
        logic exp_source;
        logic exp_hit;
        t_val exp_value;
    } t_row;

    typedef struct packed {
        logic hit;
        t_val read_value;
    } t_result;

    localparam t_row LOOKUP_TABLE [TABLE_ROWS] = '{
        '{ROW_ITEM, KIND_GET, 32'h0000_0000, 32'h0, 5'd0, EXP_TYPED, 1'b0, MISS_VALUE},
        '{ROW_ITEM, KIND_GET, 32'h8000_0000, 32'h0, 5'd0, EXP_TYPED, 1'b0, MISS_VALUE},
        '{ROW_ITEM, KIND_PUT, 32'h8000_0000, 32'h7fff_ffff, 5'd0, EXP_TYPED, 1'b0, MISS_VALUE},
        '{ROW_ITEM, KIND_PUT, 32'h7fff_ffff, 32'h8000_0000, 5'd0, EXP_TYPED, 1'b0, MISS_VALUE},
        '{ROW_ITEM, KIND_GET, 32'h8000_0000, 32'h0, 5'd0, EXP_TYPED, 1'b1, 32'h7fff_ffff},
        '{ROW_ITEM, KIND_GET, 32'h7fff_ffff, 32'h0, 5'd0, EXP_TYPED, 1'b1, 32'h8000_0000},
        '{ROW_ITEM, KIND_PUT, 32'h0000_0000, 32'h0, 5'd0, EXP_TYPED, 1'b0, MISS_VALUE},
        '{ROW_ITEM, KIND_PUT, 32'hffff_ffff, 32'hffff_ffff, 5'd0, EXP_TYPED, 1'b0, MISS_VALUE},
        '{ROW_ITEM, KIND_GET, 32'hffff_ffff, 32'h0, 5'd0, EXP_TYPED, 1'b1, 32'hffff_ffff},
        '{ROW_ITEM, KIND_PUT, 32'h8000_0000, 32'h5555_5555, 5'd0, EXP_TYPED, 1'b1, MISS_VALUE},
        '{ROW_ITEM, KIND_GET, 32'h8000_0000, 32'h0, 5'd0, EXP_TYPED, 1'b1, 32'h5555_5555},
        '{ROW_ITEM, KIND_GET, 32'h8000_0001, 32'h0, 5'd0, EXP_TYPED, 1'b0, MISS_VALUE},
        '{ROW_CFG,  KIND_GET, 32'h0, 32'h0, 5'd2, EXP_OPEN, 1'b0, MISS_VALUE},
        '{ROW_ITEM, KIND_PUT, 32'h0000_0001, 32'haaaa_aaaa, 5'd0, EXP_OPEN, 1'b0, MISS_VALUE},
        '{ROW_ITEM, KIND_GET, 32'h0000_0000, 32'h0, 5'd0, EXP_OPEN, 1'b0, MISS_VALUE},
        '{ROW_ITEM, KIND_GET, 32'h7fff_ffff, 32'h0, 5'd0, EXP_OPEN, 1'b0, MISS_VALUE},
        '{ROW_ITEM, KIND_GET, 32'h0000_0001, 32'h0, 5'd0, EXP_OPEN, 1'b0, MISS_VALUE},
        '{ROW_CFG,  KIND_GET, 32'h0, 32'h0, 5'd0, EXP_OPEN, 1'b0, MISS_VALUE},
        '{ROW_ITEM, KIND_PUT, 32'h1234_5678, 32'h0000_0001, 5'd0, EXP_OPEN, 1'b0, MISS_VALUE},
        '{ROW_ITEM, KIND_GET, 32'h1234_5678, 32'h0, 5'd0, EXP_OPEN, 1'b0, MISS_VALUE},
        '{ROW_ITEM, KIND_GET, 32'h0000_0001, 32'h0, 5'd0, EXP_OPEN, 1'b0, MISS_VALUE},
        '{ROW_CFG,  KIND_GET, 32'h0, 32'h0, 5'd31, EXP_OPEN, 1'b0, MISS_VALUE},
        '{ROW_ITEM, KIND_PUT, 32'h0000_0002, 32'h0000_0002, 5'd0, EXP_OPEN, 1'b0, MISS_VALUE},
        '{ROW_ITEM, KIND_GET, 32'h1234_5678, 32'h0, 5'd0, EXP_OPEN, 1'b0, MISS_VALUE},
        '{ROW_ITEM, KIND_GET, 32'h8000_0000, 32'h0, 5'd0, EXP_OPEN, 1'b0, MISS_VALUE}
    };

    localparam t_cfg PHASE_CAPACITY [PHASES] = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'd8, 5'd17, 5'd5};

    logic i_clk = 1'b0;
    logic i_rst_n;

    lkvc_req_if req_if ();
    lkvc_rsp_if rsp_if ();
    lkvc_cfg_if cfg_if ();

    lru_key_value_cache #(
        .MAX_ENTRIES(SLOTS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    t_key              slot_key  [SLOTS];
    t_val              slot_val  [SLOTS];
    logic              slot_used [SLOTS];
    logic [RANK_W-1:0] slot_rank [SLOTS];
    int                fill_count;
    t_cfg              capacity_reg;

    t_result pending_results [$];
    bit      send_idle_en;
    bit      recv_idle_en;
    int      items_sent;
    int      hits_seen;
    int      cfg_writes;
    int      fail_count;
    int      cycle_count;

    function automatic void promote_slot(int s);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_rank[i] < slot_rank[s]) begin
                slot_rank[i]++;
            end
        end
        slot_rank[s] = '0;
    endfunction

    function automatic t_result cache_access(logic kind, t_key key, t_val wval);
        int      found = -1;
        int      victim = -1;
        int      free_slot = -1;
        int      usable;
        t_result res;
        res.hit = 1'b0;
        res.read_value = MISS_VALUE;
        for (int i = 0; i < SLOTS; i++) begin
            if (found < 0 && slot_used[i] && slot_key[i] == key) begin
                found = i;
            end
        end
        if (found >= 0) begin
            res.hit = 1'b1;
            if (kind == KIND_GET) begin
                res.read_value = slot_val[found];
            end else begin
                slot_val[found] = wval;
            end
            promote_slot(found);
        end else if (kind == KIND_PUT) begin
            usable = (capacity_reg == 0) ? 1 : (capacity_reg > SLOTS) ? SLOTS : int'(capacity_reg);
            if (fill_count >= usable) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_used[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) begin
                        victim = i;
                    end
                end
                slot_used[victim] = 1'b0;
                slot_rank[victim] = '0;
                fill_count--;
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (free_slot < 0 && !slot_used[i]) begin
                    free_slot = i;
                end
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_used[i]) begin
                    slot_rank[i]++;
                end
            end
            slot_key[free_slot]  = key;
            slot_val[free_slot]  = wval;
            slot_used[free_slot] = 1'b1;
            slot_rank[free_slot] = '0;
            fill_count++;
        end
        return res;
    endfunction

    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(t_cfg cap);
        drain();
        cfg_if.valid          <= 1'b1;
        cfg_if.entries_in_use <= cap;
        do @(posedge i_clk); while (!cfg_if.ready);
        capacity_reg = cap;
        cfg_if.valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic send_item(logic kind, t_key key, t_val wval, logic exp_source, t_result typed);
        int      gap;
        t_result predicted;
        gap = send_idle_en ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.kind        <= kind;
        req_if.key         <= key;
        req_if.write_value <= wval;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = cache_access(kind, key, wval);
        pending_results.push_back(exp_source == EXP_TYPED ? typed : predicted);
        items_sent++;
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        t_result want;
        int      stall;
        rsp_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        rsp_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got hit %0b value %h",
                             $time, rsp_if.hit, rsp_if.read_value);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_if.hit !== want.hit) begin
                        $display("%0t: hit mismatch, expected %0b, got %0b",
                                 $time, want.hit, rsp_if.hit);
                        fail_count++;
                    end
                    if (rsp_if.read_value !== want.read_value) begin
                        $display("%0t: read_value mismatch, expected %h, got %h",
                                 $time, want.read_value, rsp_if.read_value);
                        fail_count++;
                    end
                end
                if (rsp_if.hit === 1'b1) begin
                    hits_seen++;
                end
                stall = recv_idle_en ? $urandom_range(0, 15) : 0;
                if (stall > 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    rsp_if.ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        t_key key_pool [$];
        int   pool_size;
        t_key key;
        logic kind;
        t_row row;
        i_rst_n               <= 1'b0;
        req_if.valid          <= 1'b0;
        req_if.kind           <= KIND_GET;
        req_if.key            <= '0;
        req_if.write_value    <= '0;
        cfg_if.valid          <= 1'b0;
        cfg_if.entries_in_use <= CFG_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            slot_key[i]  = '0;
            slot_val[i]  = '0;
            slot_used[i] = 1'b0;
            slot_rank[i] = '0;
        end
        fill_count   = 0;
        capacity_reg = CFG_RESET;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < TABLE_ROWS; r++) begin
            row = LOOKUP_TABLE[r];
            if (row.row_kind == ROW_CFG) begin
                write_capacity(row.capacity);
            end else begin
                send_item(row.kind, row.key, row.write_value, row.exp_source,
                          '{row.exp_hit, row.exp_value});
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            write_capacity(PHASE_CAPACITY[p]);
            send_idle_en = (p % 3 != 1);
            recv_idle_en = (p % 3 != 2);
            pool_size = $urandom_range(2, 24);
            key_pool.delete();
            for (int j = 0; j < pool_size; j++) begin
                case ($urandom_range(0, 3))
                    0: key_pool.push_back(t_key'($urandom_range(0, 31)));
                    1: begin
                        case ($urandom_range(0, 3))
                            0: key_pool.push_back(32'h8000_0000);
                            1: key_pool.push_back(32'h7fff_ffff);
                            2: key_pool.push_back(32'hffff_ffff);
                            default: key_pool.push_back(32'h0000_0000);
                        endcase
                    end
                    default: key_pool.push_back(t_key'($urandom));
                endcase
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off until the cache has answered everything
                if (n == PHASE_ITEMS / 2) begin
                    drain();
                end
                key = ($urandom_range(0, 7) == 0) ? t_key'($urandom)
                                                  : key_pool[$urandom_range(0, pool_size - 1)];
                kind = ($urandom_range(0, 1) == 1) ? KIND_PUT : KIND_GET;
                send_item(kind, key, t_val'($urandom), EXP_OPEN, '{1'b0, MISS_VALUE});
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("ran %0d items (%0d from the table) over %0d capacity writes, %0d hits returned",
                 items_sent, TABLE_ROWS - 3, cfg_writes, hits_seen);
        $display("capacities spanned zero, one, lowered below occupancy and beyond the depth");
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
